/* hdl/nfudc_pkg.sv */
// Shared widths, codes and control bundles of the number-field unit distance check.
// Used by the store, MAC, sequencer and core modules; depends on nothing else.
package nfudc_pkg;

  localparam int COEFF_BITS = 21;
  localparam int DIFF_W     = COEFF_BITS + 1;
  localparam int CONJ_W     = COEFF_BITS + 2;
  localparam int PROD_W     = DIFF_W + CONJ_W;
  localparam int ACC_W      = 64;
  localparam int NORM_W     = 32;
  localparam int POS_W      = 4;
  localparam int GRP_W      = 2;
  localparam int NUM_POS    = 16;
  localparam int NUM_GRP    = 4;

  localparam logic [NORM_W-1:0] NORM_RESET = NORM_W'(9216);

  // Scale codes: bit 0 set means both sides carry sqrt(-3), bit 1 means sqrt(-11).
  localparam logic [1:0] SCALE_ONE = 2'b00;
  localparam logic [1:0] SCALE_M3  = 2'b01;
  localparam logic [1:0] SCALE_M11 = 2'b10;
  localparam logic [1:0] SCALE_P33 = 2'b11;

  typedef struct packed {
    logic [POS_W-1:0] diff_raddr;
    logic [POS_W-1:0] conj_raddr;
    logic             x1_load;
    logic             conj_we;
    logic [POS_W-1:0] conj_waddr;
    logic             conj_zero;
    logic             conj_neg;
  } store_ctrl_t;

  typedef struct packed {
    logic [1:0]       scale_sel;
    logic             fold;
    logic [POS_W-1:0] acc_idx;
  } mac_tag_t;

  typedef struct packed {
    logic             clear;
    logic             issue;
    mac_tag_t         tag;
    logic             check;
    logic [POS_W-1:0] check_idx;
  } mac_ctrl_t;

endpackage

/* hdl/nfudc_store.sv */
// Difference store and conjugate store with the conjugation datapath.
// Depends on nfudc_pkg; controlled by nfudc_seq.
module nfudc_store (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [nfudc_pkg::POS_W-1:0]         wr_addr,
  input  logic signed [nfudc_pkg::COEFF_BITS-1:0] wr_first,
  input  logic signed [nfudc_pkg::COEFF_BITS-1:0] wr_second,
  input  nfudc_pkg::store_ctrl_t              sc,
  output logic signed [nfudc_pkg::DIFF_W-1:0] diff_rd,
  output logic signed [nfudc_pkg::CONJ_W-1:0] conj_rd
);
  import nfudc_pkg::*;

  logic signed [DIFF_W-1:0] diff_r [NUM_POS];
  logic signed [CONJ_W-1:0] conj_r [NUM_POS];
  logic signed [DIFF_W-1:0] x1_r;
  logic signed [DIFF_W-1:0] wr_diff;
  logic signed [DIFF_W-1:0] conj_src;
  logic signed [CONJ_W-1:0] conj_delta;
  logic signed [CONJ_W-1:0] conj_wdata;

  assign wr_diff = {wr_first[COEFF_BITS-1], wr_first} - {wr_second[COEFF_BITS-1], wr_second};

  assign diff_rd = diff_r[sc.diff_raddr];
  assign conj_rd = conj_r[sc.conj_raddr];

  // The z power term is subtracted from every position of its group.
  assign conj_src   = sc.conj_zero ? '0 : diff_rd;
  assign conj_delta = {conj_src[DIFF_W-1], conj_src} - {x1_r[DIFF_W-1], x1_r};
  assign conj_wdata = sc.conj_neg ? -conj_delta : conj_delta;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      diff_r[wr_addr] <= wr_diff;
    end
    if (sc.x1_load) begin
      x1_r <= diff_rd;
    end
    if (sc.conj_we) begin
      conj_r[sc.conj_waddr] <= conj_wdata;
    end
  end

endmodule

/* hdl/nfudc_mac.sv */
// Shared multiplier pipeline, field-rule scaling, accumulators and final compare.
// Depends on nfudc_pkg; fed by nfudc_store and driven by nfudc_seq.
module nfudc_mac (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  nfudc_pkg::mac_ctrl_t                 mc,
  input  logic signed [nfudc_pkg::DIFF_W-1:0]  diff_rd,
  input  logic signed [nfudc_pkg::CONJ_W-1:0]  conj_rd,
  input  logic [nfudc_pkg::NORM_W-1:0]         target_norm,
  output logic                                 busy,
  output logic                                 is_unit
);
  import nfudc_pkg::*;

  logic                     v1_r, v2_r, v3_r;
  logic signed [DIFF_W-1:0] a_r;
  logic signed [CONJ_W-1:0] b_r;
  logic signed [PROD_W-1:0] p_r;
  logic [ACC_W-1:0]         s_r;
  mac_tag_t                 tag1_r, tag2_r, tag3_r;
  logic [ACC_W-1:0]         acc_r  [NUM_POS];
  logic [ACC_W-1:0]         fold_r [NUM_GRP];
  logic                     ok_r;

  logic [ACC_W-1:0] pe;
  logic [ACC_W-1:0] s_nxt;
  logic [ACC_W-1:0] chk_val;
  logic [ACC_W-1:0] chk_exp;

  assign busy    = v1_r | v2_r | v3_r;
  assign is_unit = ok_r;

  assign pe = {{(ACC_W-PROD_W){p_r[PROD_W-1]}}, p_r};

  always_comb begin
    case (tag2_r.scale_sel)
      SCALE_ONE: s_nxt = pe;
      SCALE_M3:  s_nxt = '0 - (pe + (pe << 1));
      SCALE_M11: s_nxt = '0 - (pe + (pe << 1) + (pe << 3));
      SCALE_P33: s_nxt = pe + (pe << 5);
      default:   s_nxt = pe;
    endcase
  end

  // Folded terms are tallied per group and subtracted from all four positions here.
  assign chk_val = acc_r[mc.check_idx] - fold_r[mc.check_idx[POS_W-1:POS_W-GRP_W]];
  assign chk_exp = (mc.check_idx == '0) ? {{(ACC_W-NORM_W){1'b0}}, target_norm} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= mc.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= diff_rd;
    b_r    <= conj_rd;
    tag1_r <= mc.tag;
    p_r    <= a_r * b_r;
    tag2_r <= tag1_r;
    s_r    <= s_nxt;
    tag3_r <= tag2_r;
    if (mc.clear) begin
      for (int n = 0; n < NUM_POS; n++) begin
        acc_r[n] <= '0;
      end
      for (int g = 0; g < NUM_GRP; g++) begin
        fold_r[g] <= '0;
      end
      ok_r <= 1'b1;
    end else begin
      if (v3_r) begin
        if (tag3_r.fold) begin
          fold_r[tag3_r.acc_idx[POS_W-1:POS_W-GRP_W]] <=
            fold_r[tag3_r.acc_idx[POS_W-1:POS_W-GRP_W]] + s_r;
        end else begin
          acc_r[tag3_r.acc_idx] <= acc_r[tag3_r.acc_idx] + s_r;
        end
      end
      if (mc.check) begin
        ok_r <= ok_r & (chk_val == chk_exp);
      end
    end
  end

endmodule

/* hdl/nfudc_seq.sv */
// Sequencer: conjugation pass, 256 product issues, pipeline drain, compare sweep and result load.
// Depends on nfudc_pkg; drives nfudc_store and nfudc_mac.
module nfudc_seq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_fire,
  input  logic                   in_last,
  input  logic                   mac_busy,
  input  logic                   out_free,
  output logic                   in_ready,
  output logic                   out_load,
  output nfudc_pkg::store_ctrl_t sc,
  output nfudc_pkg::mac_ctrl_t   mc
);
  import nfudc_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CONJ_X1 = 3'd1;
  localparam logic [2:0] ST_CONJ_WR = 3'd2;
  localparam logic [2:0] ST_MUL     = 3'd3;
  localparam logic [2:0] ST_DRAIN   = 3'd4;
  localparam logic [2:0] ST_CHECK   = 3'd5;
  localparam logic [2:0] ST_DONE    = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [GRP_W-1:0] grp_r, grp_nxt;
  logic [1:0]       h_r, h_nxt;
  logic [POS_W-1:0] i_r, i_nxt;
  logic [POS_W-1:0] j_r, j_nxt;
  logic [POS_W-1:0] k_r, k_nxt;

  logic [1:0] perm;
  logic [2:0] pw;
  logic [2:0] pw_mod;

  // Conjugation maps z^k to z^(5-k): positions 2 and 3 swap, z^1 folds.
  always_comb begin
    case (h_r)
      2'd2:    perm = 2'd3;
      2'd3:    perm = 2'd2;
      default: perm = 2'd0;
    endcase
  end

  assign pw     = {1'b0, i_r[1:0]} + {1'b0, j_r[1:0]};
  assign pw_mod = (pw >= 3'd5) ? (pw - 3'd5) : pw;

  always_comb begin
    state_nxt = state_r;
    grp_nxt   = grp_r;
    h_nxt     = h_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    sc        = '0;
    mc        = '0;
    sc.diff_raddr = i_r;
    sc.conj_raddr = j_r;
    mc.check_idx  = k_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire && in_last) begin
          mc.clear  = 1'b1;
          grp_nxt   = '0;
          state_nxt = ST_CONJ_X1;
        end
      end
      ST_CONJ_X1: begin
        sc.diff_raddr = {grp_r, 2'd1};
        sc.x1_load    = 1'b1;
        h_nxt         = '0;
        state_nxt     = ST_CONJ_WR;
      end
      ST_CONJ_WR: begin
        sc.diff_raddr = {grp_r, perm};
        sc.conj_we    = 1'b1;
        sc.conj_waddr = {grp_r, h_r};
        sc.conj_zero  = (h_r == 2'd1);
        sc.conj_neg   = grp_r[0] ^ grp_r[1];
        h_nxt         = h_r + 2'd1;
        if (h_r == 2'd3) begin
          grp_nxt = grp_r + GRP_W'(1);
          if (grp_r == GRP_W'(NUM_GRP - 1)) begin
            i_nxt     = '0;
            j_nxt     = '0;
            state_nxt = ST_MUL;
          end else begin
            state_nxt = ST_CONJ_X1;
          end
        end
      end
      ST_MUL: begin
        mc.issue             = 1'b1;
        mc.tag.scale_sel     = i_r[3:2] & j_r[3:2];
        mc.tag.fold          = (pw == 3'd4);
        mc.tag.acc_idx       = {i_r[3:2] ^ j_r[3:2], pw_mod[1:0]};
        j_nxt                = j_r + POS_W'(1);
        if (j_r == POS_W'(NUM_POS - 1)) begin
          i_nxt = i_r + POS_W'(1);
          if (i_r == POS_W'(NUM_POS - 1)) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          k_nxt     = '0;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        mc.check = 1'b1;
        k_nxt    = k_r + POS_W'(1);
        if (k_r == POS_W'(NUM_POS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      grp_r   <= '0;
      h_r     <= '0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      grp_r   <= grp_nxt;
      h_r     <= h_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

/* hdl/number_field_unit_distance_check_core.sv */
// Unit distance check in a 16-dimensional exact number field.
// Each input request loads one basis coefficient of two points; the block stores
// their difference. A request with in_last_coeff set starts the check: the
// stored difference is conjugated and multiplied by itself under the field
// rules, and one result request reports whether the squared distance equals
// the configured target norm with every irrational component zero.
// Input channel: in_valid/in_ready. After a request without the last flag
// in_ready stays high. A request with the last flag makes in_ready drop for the
// check: a conjugation pass, 256 products through one shared multiplier (one
// product per cycle), a pipeline drain, a compare sweep over the 16 positions
// and the result load; in_ready returns once the result is loaded, which waits
// for the output register to be free.
// Result channel: out_valid/out_ready with an output register, so new loads
// are taken while a result waits. If a second check finishes while the
// receiver still stalls the first result, the block holds until it is taken.
// cfg_wr_en/cfg_wr_data write target_norm in the same cycle; write it only
// while no check runs. Reset is synchronous, active low: target_norm returns
// to 9216, no result is pending and the block is ready. Stored differences
// are not cleared and must be loaded before they take part in a check.
module number_field_unit_distance_check_core (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [nfudc_pkg::POS_W-1:0]              in_coord_index,
  input  logic signed [nfudc_pkg::COEFF_BITS-1:0]  in_first_coeff,
  input  logic signed [nfudc_pkg::COEFF_BITS-1:0]  in_second_coeff,
  input  logic                                     in_last_coeff,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic                                     out_is_unit,
  input  logic                                     cfg_wr_en,
  input  logic [nfudc_pkg::NORM_W-1:0]             cfg_wr_data
);
  import nfudc_pkg::*;

  logic [NORM_W-1:0]        target_norm_r;
  logic                     out_valid_r;
  logic                     out_is_unit_r;
  logic                     in_fire;
  logic                     out_free;
  logic                     out_load;
  logic                     mac_busy;
  logic                     mac_is_unit;
  store_ctrl_t              sc;
  mac_ctrl_t                mc;
  logic signed [DIFF_W-1:0] diff_rd;
  logic signed [CONJ_W-1:0] conj_rd;

  assign in_fire     = in_valid & in_ready;
  // The output register may be reloaded in the cycle its request is taken.
  assign out_free    = ~out_valid_r | out_ready;
  assign out_valid   = out_valid_r;
  assign out_is_unit = out_is_unit_r;

  nfudc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_last  (in_last_coeff),
    .mac_busy (mac_busy),
    .out_free (out_free),
    .in_ready (in_ready),
    .out_load (out_load),
    .sc       (sc),
    .mc       (mc)
  );

  nfudc_store u_store (
    .clk       (clk),
    .wr_en     (in_fire),
    .wr_addr   (in_coord_index),
    .wr_first  (in_first_coeff),
    .wr_second (in_second_coeff),
    .sc        (sc),
    .diff_rd   (diff_rd),
    .conj_rd   (conj_rd)
  );

  nfudc_mac u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .mc          (mc),
    .diff_rd     (diff_rd),
    .conj_rd     (conj_rd),
    .target_norm (target_norm_r),
    .busy        (mac_busy),
    .is_unit     (mac_is_unit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_norm_r <= NORM_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        target_norm_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_is_unit_r <= mac_is_unit;
    end
  end

endmodule

/* hdl/nfudc_checker.sv */
// Port-level checks of the unit distance check core, attached by bind.
// Depends on number_field_unit_distance_check_core.
module nfudc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_last_coeff,
  input logic out_valid,
  input logic out_ready,
  input logic out_is_unit
);

  // A stalled result request keeps its flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_is_unit))
    else $error("result request changed while stalled");

  // A last coefficient starts a check, so loading stops at once.
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_coeff |=> !in_ready)
    else $error("input still ready after a last coefficient");

  // After a plain coefficient load the input stays ready.
  a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last_coeff |=> in_ready)
    else $error("input not ready after a plain load");

  // A new result only appears at the end of a check.
  a_result_after_check: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a finished check");

endmodule

bind number_field_unit_distance_check_core nfudc_checker u_nfudc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_last_coeff (in_last_coeff),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_is_unit   (out_is_unit)
);

/* dv/number_field_unit_distance_check_core_test.sv */
// Self-checking testbench of number_field_unit_distance_check_core.
// Depends on nfudc_pkg and the core; predicts every is_unit flag on its own.
`timescale 1ns / 100ps

module number_field_unit_distance_check_core_test;

  import nfudc_pkg::*;

  // Longest quiet stretch on both channels before the run is declared hung.
  localparam int HANG_LIMIT    = 4000;
  // Cycles left after the last result before the block counts as idle.
  localparam int SETTLE_CYCLES = 400;
  localparam int MAX_REPORTS   = 10;
  localparam int COEFF_MAX     = 1000000;

  // Products in the sqrt(-3) and sqrt(-11) groups pick up the squares of
  // those roots, taken modulo 2^64 like the accumulators.
  localparam logic [ACC_W-1:0] SQ_ROOT3  = 64'hFFFF_FFFF_FFFF_FFFD;
  localparam logic [ACC_W-1:0] SQ_ROOT11 = 64'hFFFF_FFFF_FFFF_FFF5;

  typedef struct {
    logic [POS_W-1:0]             pos;
    logic signed [COEFF_BITS-1:0] first;
    logic signed [COEFF_BITS-1:0] second;
    logic                         last;
  } coeff_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [POS_W-1:0]             in_coord_index = '0;
  logic signed [COEFF_BITS-1:0] in_first_coeff = '0;
  logic signed [COEFF_BITS-1:0] in_second_coeff = '0;
  logic                         in_last_coeff = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         out_is_unit;
  logic                         cfg_wr_en = 1'b0;
  logic [NORM_W-1:0]            cfg_wr_data = '0;

  number_field_unit_distance_check_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_coord_index  (in_coord_index),
    .in_first_coeff  (in_first_coeff),
    .in_second_coeff (in_second_coeff),
    .in_last_coeff   (in_last_coeff),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_is_unit     (out_is_unit),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  always #10 clk = ~clk;

  // Requests still to be driven, and the flags that accepted checks must yield.
  coeff_req_t pending_reqs[$];
  logic       expected_flags[$];

  // Our own copy of the block's state: stored differences, kept at 64 bits as
  // the accumulators see them, and the current target norm.
  logic [ACC_W-1:0]  diff_shadow [NUM_POS];
  logic [NORM_W-1:0] norm_target = NORM_RESET;

  int failures = 0;
  int phase_items;
  int idle_cycles = 0;

  // Flags that pass an acceptance from the rising edge to the driving edge.
  bit req_taken = 1'b0;
  bit flag_taken = 1'b0;
  int send_gap = 0;
  int recv_stall = 0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;

  // Squared distance of the stored difference: multiply it by its conjugate
  // with the field rules and test for the target with no irrational part.
  function automatic logic unit_norm_holds();
    logic [ACC_W-1:0] conj_vec [NUM_POS];
    logic [ACC_W-1:0] norm_acc [NUM_POS];
    logic [ACC_W-1:0] x;
    logic [ACC_W-1:0] prod;
    int g, p, h, i, j, pw, slot;
    logic holds;
    for (i = 0; i < NUM_POS; i++) begin
      conj_vec[i] = '0;
      norm_acc[i] = '0;
    end
    // Conjugation flips the sign of the single square roots, keeps their
    // product, and sends z^k to z^(5-k); z^4 expands to -(1+z+z^2+z^3).
    for (g = 0; g < NUM_GRP; g++) begin
      for (p = 0; p < 4; p++) begin
        x = diff_shadow[4*g + p];
        if (g == 1 || g == 2) x = '0 - x;
        if (p == 1) begin
          for (h = 0; h < 4; h++) conj_vec[4*g + h] = conj_vec[4*g + h] - x;
        end else if (p == 0) begin
          conj_vec[4*g] = conj_vec[4*g] + x;
        end else begin
          conj_vec[4*g + 5 - p] = conj_vec[4*g + 5 - p] + x;
        end
      end
    end
    for (i = 0; i < NUM_POS; i++) begin
      for (j = 0; j < NUM_POS; j++) begin
        pw   = (i & 3) + (j & 3);
        slot = ((i >> 2) ^ (j >> 2)) * 4;
        prod = diff_shadow[i] * conj_vec[j];
        if (((i >> 2) & (j >> 2) & 1) != 0) prod = prod * SQ_ROOT3;
        if (((i >> 2) & (j >> 2) & 2) != 0) prod = prod * SQ_ROOT11;
        if (pw == 4) begin
          for (h = 0; h < 4; h++) norm_acc[slot + h] = norm_acc[slot + h] - prod;
        end else begin
          norm_acc[slot + (pw % 5)] = norm_acc[slot + (pw % 5)] + prod;
        end
      end
    end
    holds = (norm_acc[0] == {32'd0, norm_target});
    for (i = 1; i < NUM_POS; i++) if (norm_acc[i] != '0) holds = 1'b0;
    return holds;
  endfunction

  // Rising edge: bookkeeping of both channels and the hang watchdog.
  always @(posedge clk) begin
    logic signed [ACC_W-1:0] lhs;
    logic signed [ACC_W-1:0] rhs;
    logic want;
    if (in_valid && in_ready) begin
      lhs = in_first_coeff;
      rhs = in_second_coeff;
      diff_shadow[in_coord_index] = lhs - rhs;
      if (in_last_coeff) expected_flags.push_back(unit_norm_holds());
      req_taken = 1'b1;
    end
    if (out_valid && out_ready) begin
      flag_taken = 1'b1;
      if (expected_flags.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("Unexpected result request: is_unit=%0b", out_is_unit);
      end else begin
        want = expected_flags.pop_front();
        if (out_is_unit !== want) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("is_unit mismatch: expected %0b, actual %0b", want, out_is_unit);
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Request driver: after each accepted request it waits a random number of
  // cycles, with stretches where it sends back to back.
  always @(negedge clk) begin
    logic next_valid;
    coeff_req_t req;
    next_valid = in_valid;
    if (rst_n) begin
      if (in_valid && req_taken) begin
        req_taken  = 1'b0;
        next_valid = 1'b0;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 19);
      end
      if (!next_valid && pending_reqs.size() != 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end else begin
          req = pending_reqs.pop_front();
          in_coord_index  <= req.pos;
          in_first_coeff  <= req.first;
          in_second_coeff <= req.second;
          in_last_coeff   <= req.last;
          next_valid = 1'b1;
        end
      end
    end
    in_valid <= next_valid;
  end

  // Result receiver: each result is held off for a random number of cycles
  // counted only while the block offers it.
  always @(negedge clk) begin
    logic next_ready;
    next_ready = out_ready;
    if (rst_n) begin
      if (flag_taken) begin
        flag_taken = 1'b0;
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_stall = recv_burst ? 0 : $urandom_range(0, 19);
        next_ready = (recv_stall == 0);
      end else if (!out_ready) begin
        if (recv_stall == 0) next_ready = 1'b1;
        else if (out_valid) recv_stall--;
      end
    end
    out_ready <= next_ready;
  end

  task automatic push_req(input int pos, input int first, input int second, input bit last);
    coeff_req_t req;
    req.pos    = pos[POS_W-1:0];
    req.first  = first[COEFF_BITS-1:0];
    req.second = second[COEFF_BITS-1:0];
    req.last   = last;
    pending_reqs.push_back(req);
    phase_items++;
  endtask

  // Loads a difference d, choosing a random first coefficient so that both
  // coefficients stay inside their range.
  task automatic push_diff(input int pos, input int d, input bit last);
    int lo, hi, first;
    lo = (d > 0) ? d - COEFF_MAX : -COEFF_MAX;
    hi = (d > 0) ? COEFF_MAX : d + COEFF_MAX;
    first = lo + int'($urandom_range(0, hi - lo));
    push_req(pos, first, first - d, last);
  endtask

  function automatic int wide_diff();
    return int'($urandom_range(0, 4 * COEFF_MAX)) - 2 * COEFF_MAX;
  endfunction

  // One complete point pair: all sixteen positions in random order, with the
  // last flag on the final request.
  task automatic push_vector(input int vec [NUM_POS]);
    int order [NUM_POS];
    int i, j, t;
    for (i = 0; i < NUM_POS; i++) order[i] = i;
    for (i = NUM_POS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (i = 0; i < NUM_POS; i++) push_diff(order[i], vec[order[i]], i == NUM_POS - 1);
  endtask

  // One random check, or some loose requests. Most are well-formed point
  // pairs; unit candidates use the root group and magnitude of the phase.
  task automatic push_random_check(input int grp, input int mag);
    int vec [NUM_POS];
    int i, n, roll, s;
    for (i = 0; i < NUM_POS; i++) vec[i] = 0;
    s = $urandom_range(0, 1) ? mag : -mag;
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      // A single basis element scaled by the magnitude.
      vec[4*grp + $urandom_range(0, 3)] = s;
      push_vector(vec);
    end else if (roll < 40) begin
      // Equal coefficients on 1, z, z^2, z^3: minus the fourth power of z.
      for (i = 0; i < 4; i++) vec[4*grp + i] = s;
      push_vector(vec);
    end else if (roll < 50) begin
      // A unit candidate knocked off by one.
      vec[4*grp + $urandom_range(0, 3)] = s;
      vec[$urandom_range(0, NUM_POS - 1)] += $urandom_range(0, 1) ? 1 : -1;
      push_vector(vec);
    end else if (roll < 65) begin
      for (i = 0; i < NUM_POS; i++) vec[i] = wide_diff();
      push_vector(vec);
    end else if (roll < 75) begin
      for (i = 0; i < NUM_POS; i++)
        if ($urandom_range(0, 1)) vec[i] = int'($urandom_range(0, 6)) - 3;
      push_vector(vec);
    end else if (roll < 90) begin
      // Rewrite a few positions and check again; the rest is kept.
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++)
        push_diff($urandom_range(0, NUM_POS - 1),
                  $urandom_range(0, 1) ? 0 : int'($urandom_range(0, 400)) - 200,
                  i == n - 1);
    end else begin
      // Loose requests without the last flag.
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) push_diff($urandom_range(0, NUM_POS - 1), wide_diff(), 1'b0);
    end
  endtask

  // Waits until every request went in and every result came out, then lets
  // the block finish any work that yields no result.
  task automatic drain_block();
    while (pending_reqs.size() != 0 || in_valid || expected_flags.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [NORM_W-1:0] target, input int grp, input int mag,
                           input bit write_cfg, input int item_goal);
    if (write_cfg) begin
      drain_block();
      @(negedge clk);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= target;
      norm_target = target;
      @(negedge clk);
      cfg_wr_en <= 1'b0;
    end
    phase_items = 0;
    while (phase_items < item_goal) push_random_check(grp, mag);
  endtask

  initial begin
    int pos, same;
    int rand_grp, rand_mag;
    int grp_factor [NUM_GRP];
    grp_factor[0] = 1;
    grp_factor[1] = 3;
    grp_factor[2] = 11;
    grp_factor[3] = 33;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset target. First a full load whose only
    // nonzero difference is 96 at the rational position, built from
    // coefficients at the range ends: a unit at the reset target.
    phase_items = 0;
    push_req(0, -999904, -COEFF_MAX, 1'b0);
    for (pos = 1; pos < NUM_POS; pos++) begin
      same = (pos % 3 == 0) ? COEFF_MAX : (pos % 3 == 1) ? -COEFF_MAX : 0;
      push_req(pos, same, same, pos == NUM_POS - 1);
    end
    // Stored entries are kept between checks: spoil one, then restore it.
    push_req(3, COEFF_MAX, -COEFF_MAX, 1'b1);
    push_req(3, -COEFF_MAX, -COEFF_MAX, 1'b1);
    push_req(0, -COEFF_MAX, COEFF_MAX, 1'b1);
    push_req(0, 0, 96, 1'b1);

    // Random phases, one target each, extremes among them.
    run_phase(NORM_RESET, 0, 96, 1'b0, 80);
    run_phase(NORM_W'(27648), 1, 96, 1'b1, 100);
    run_phase('0, 0, 0, 1'b1, 100);
    run_phase('1, 2, 0, 1'b1, 100);
    run_phase(NORM_W'(101376), 2, 96, 1'b1, 100);
    run_phase(NORM_W'(304128), 3, 96, 1'b1, 100);
    rand_grp = $urandom_range(0, NUM_GRP - 1);
    rand_mag = $urandom_range(1, 11400);
    run_phase(NORM_W'(rand_mag * rand_mag * grp_factor[rand_grp]), rand_grp, rand_mag,
              1'b1, 100);
    run_phase(NORM_W'(32'd4294836225), 0, 65535, 1'b1, 100);
    run_phase(NORM_RESET, 0, 96, 1'b1, 100);

    drain_block();
    failures += expected_flags.size();
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/nfudc_pkg.sv
hdl/nfudc_store.sv
hdl/nfudc_mac.sv
hdl/nfudc_seq.sv
hdl/number_field_unit_distance_check_core.sv
hdl/nfudc_checker.sv
dv/number_field_unit_distance_check_core_test.sv
